// File: design/assert_macros.svh
// Concurrent assertion helpers used by the recognizer design file.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check prop on every rising edge of clk while rst_n is high.
`define ASSERT_RST(label, prop, clk, rst_n) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that cond never holds on a rising edge of clk while rst_n is high.
`define ASSERT_NEVER(label, cond, clk, rst_n) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_RST(label, prop, clk, rst_n)
`define ASSERT_NEVER(label, cond, clk, rst_n)

`endif

`endif

// File: design/sexp_tok_pkg.sv
package sexp_tok_pkg;

  typedef enum logic [1:0] {
    K_FLOAT = 2'd0,
    K_INT   = 2'd1,
    K_STR   = 2'd2,
    K_SYM   = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    P_IDLE   = 4'd0,
    P_FSTART = 4'd1,
    P_FMANT  = 4'd2,
    P_FEXP   = 4'd3,
    P_FESIGN = 4'd4,
    P_FEDIG  = 4'd5,
    P_ISTART = 4'd6,
    P_ISIGN  = 4'd7,
    P_IDIG   = 4'd8,
    P_SSTART = 4'd9,
    P_SIN    = 4'd10,
    P_SDONE  = 4'd11,
    P_YSTART = 4'd12,
    P_YPEC   = 4'd13,
    P_YBODY  = 4'd14
  } phase_e;

  // Mantissa flag bits
  localparam int unsigned FlagDigit = 0;
  localparam int unsigned FlagPoint = 1;

  typedef struct packed {
    phase_e     nxt;    // P_IDLE when the character ends the scan
    logic       acc;    // token is acceptable after this character
    logic [1:0] flags;  // updated mantissa flags
  } step_t;

  typedef struct packed {
    logic [7:0] len;
    logic       unterm;
    logic       too_long;
  } res_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_sign(logic [7:0] c);
    return (c == "+") || (c == "-");
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c == 8'h0A) || (c == 8'h0D) || (c == 8'h09);
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    return (c == "(") || (c == ")") || (c == ";");
  endfunction

  function automatic logic is_initial(logic [7:0] c);
    logic mark;
    mark = (c == "!") || (c == "$") || (c == "%") || (c == "&") || (c == "*") ||
           (c == "/") || (c == ":") || (c == "<") || (c == "=") || (c == ">") ||
           (c == "?") || (c == "^") || (c == "_") || (c == "~");
    return is_alpha(c) || mark;
  endfunction

  function automatic logic is_subsequent(logic [7:0] c);
    return is_initial(c) || is_digit(c) || is_sign(c) || (c == ".") || (c == "@");
  endfunction

  function automatic phase_e start_phase(kind_e k);
    phase_e p;
    unique case (k)
      K_FLOAT: p = P_FSTART;
      K_INT:   p = P_ISTART;
      K_STR:   p = P_SSTART;
      K_SYM:   p = P_YSTART;
      default: p = P_IDLE;
    endcase
    return p;
  endfunction

endpackage

// File: design/sexp_token_end_recognizer.sv
// Channel   Dir  Beat                          Fields (lowest bit first)
// s_axis    in   one text character            tdata: ch[7:0]; tuser: start_req
// m_axis    out  one finished token            tdata: match_length[7:0];
//                                              tuser: unterminated, too_long
// cfg       in   grammar select write          cfg_data_i: token_kind[1:0]
//
// One character per clock: each beat is decoded by the phase logic and folded
// into the scan state in the same cycle it is accepted; a token that ends
// is registered on that edge, in the result register or, while that is held, in the skid.
// Results pass through a two-entry buffer (result register plus skid), so
// s_axis stays ready while one result waits; it drops only while the skid is
// full. Reset clears the scan state, the grammar select and both buffer
// entries; no clearing pass is needed.
module sexp_token_end_recognizer
  import sexp_tok_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] ch
  input  logic       s_axis_tuser,   // [0] start_req

  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] match_length
  output logic [1:0] m_axis_tuser,   // [0] unterminated, [1] too_long

  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i      // [1:0] token_kind
);

`include "assert_macros.svh"

  // Length cap: the count register is eight bits wide
  localparam int         LenLimitInt = (MAX_TOKEN_LEN > 255) ? 255 : MAX_TOKEN_LEN;
  localparam logic [7:0] LenLimit    = 8'(LenLimitInt);

  kind_e      kind_q;
  logic       scanning_q, scanning_d;
  phase_e     phase_q, phase_d;
  logic [7:0] count_q, count_d;
  logic [7:0] last_q, last_d;
  logic       bs_q, bs_d;
  logic [1:0] flags_q, flags_d;

  // Scan state as seen by the current beat (a start beat opens a fresh scan)
  logic       cur_scan;
  phase_e     cur_phase;
  logic [7:0] cur_count;
  logic [7:0] cur_last;
  logic       cur_bs;
  logic [1:0] cur_flags;
  logic [7:0] count_inc;
  logic       is_sym;

  step_t      step;
  logic       in_fire;
  logic       res_vld;
  res_t       res;

  // Result buffer: main register drives the port, skid catches one more
  logic       main_vld_q, skid_vld_q;
  res_t       main_q, skid_q;
  logic       main_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= K_FLOAT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      kind_q <= kind_e'(cfg_data_i);
    end
  end

  assign s_axis_tready = !skid_vld_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign cur_scan  = s_axis_tuser || scanning_q;
  assign cur_phase = s_axis_tuser ? start_phase(kind_q) : phase_q;
  assign cur_count = s_axis_tuser ? 8'd0 : count_q;
  assign cur_last  = s_axis_tuser ? 8'd0 : last_q;
  assign cur_bs    = s_axis_tuser ? 1'b0 : bs_q;
  assign cur_flags = s_axis_tuser ? 2'b00 : flags_q;
  assign count_inc = 8'(cur_count + 8'd1);
  assign is_sym    = (cur_phase == P_YPEC) || (cur_phase == P_YBODY);

  sexp_tok_step u_step (
    .phase_i   (cur_phase),
    .flags_i   (cur_flags),
    .prev_bs_i (cur_bs),
    .ch_i      (s_axis_tdata),
    .step_o    (step)
  );

  // Fold one character into the scan; flag a result when the token closes
  always_comb begin
    scanning_d = cur_scan;
    phase_d    = cur_phase;
    count_d    = cur_count;
    last_d     = cur_last;
    bs_d       = cur_bs;
    flags_d    = cur_flags;
    res_vld    = 1'b0;
    res        = '0;
    if (cur_scan) begin
      if (step.nxt == P_IDLE) begin
        // no extension: longest accepted prefix, 0 for a symbol not ended by blank/delim
        res_vld      = 1'b1;
        res.len      = (is_sym && !is_delim(s_axis_tdata) && !is_space(s_axis_tdata))
                       ? 8'd0 : cur_last;
        res.unterm   = (cur_phase == P_SIN);
        scanning_d   = 1'b0;
        phase_d      = P_IDLE;
      end else if (cur_count >= LenLimit) begin
        // would overrun the length cap: saturate at the last accept
        res_vld      = 1'b1;
        res.len      = cur_last;
        res.unterm   = (cur_phase == P_SIN);
        res.too_long = 1'b1;
        scanning_d   = 1'b0;
        phase_d      = P_IDLE;
      end else begin
        count_d = count_inc;
        bs_d    = (cur_phase == P_SIN) && (s_axis_tdata == "\\") && !cur_bs;
        flags_d = step.flags;
        if (step.acc) last_d = count_inc;
        if (step.nxt == P_SDONE) begin
          // closing quote: the whole string is the token
          res_vld    = 1'b1;
          res.len    = count_inc;
          scanning_d = 1'b0;
          phase_d    = P_IDLE;
        end else begin
          phase_d = step.nxt;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scanning_q <= 1'b0;
      phase_q    <= P_IDLE;
      count_q    <= 8'd0;
      last_q     <= 8'd0;
      bs_q       <= 1'b0;
      flags_q    <= 2'b00;
    end else if (in_fire) begin
      scanning_q <= scanning_d;
      phase_q    <= phase_d;
      count_q    <= count_d;
      last_q     <= last_d;
      bs_q       <= bs_d;
      flags_q    <= flags_d;
    end
  end

  assign main_free = !main_vld_q || m_axis_tready;

  // Advance the buffer: the skid drains into the main register first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (main_free) begin
      main_vld_q <= skid_vld_q || (in_fire && res_vld);
      skid_vld_q <= 1'b0;
    end else if (in_fire && res_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_free) begin
      main_q <= skid_vld_q ? skid_q : res;
    end else if (in_fire && res_vld) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = main_vld_q;
  assign m_axis_tdata  = main_q.len;
  assign m_axis_tuser  = {main_q.too_long, main_q.unterm};

  `ASSERT_RST(a_skid_behind_main, skid_vld_q |-> main_vld_q, clk_i, rst_ni)
  `ASSERT_RST(a_scan_has_phase, scanning_q |-> (phase_q != P_IDLE), clk_i, rst_ni)
  `ASSERT_RST(a_count_capped, scanning_q |-> (count_q <= LenLimit), clk_i, rst_ni)
  `ASSERT_RST(a_accept_in_count, scanning_q |-> (last_q <= count_q), clk_i, rst_ni)
  `ASSERT_NEVER(a_result_needs_scan, in_fire && res_vld && !cur_scan, clk_i, rst_ni)

endmodule

// File: design/sexp_tok_step.sv
module sexp_tok_step
  import sexp_tok_pkg::*;
(
  input  phase_e     phase_i,
  input  logic [1:0] flags_i,
  input  logic       prev_bs_i,
  input  logic [7:0] ch_i,
  output step_t      step_o
);

  logic printable;

  assign printable = ((ch_i >= 8'h21) && (ch_i <= 8'h7E)) || is_space(ch_i);

  always_comb begin
    step_o.nxt   = P_IDLE;
    step_o.acc   = 1'b0;
    step_o.flags = flags_i;
    unique case (phase_i)
      P_FSTART, P_FMANT: begin
        if ((phase_i == P_FSTART) && is_sign(ch_i)) begin
          step_o.nxt = P_FMANT;
        end else if (is_digit(ch_i)) begin
          step_o.flags[FlagDigit] = 1'b1;
          step_o.acc = flags_i[FlagPoint];
          step_o.nxt = P_FMANT;
        end else if ((ch_i == ".") && !flags_i[FlagPoint]) begin
          step_o.flags[FlagPoint] = 1'b1;
          step_o.acc = flags_i[FlagDigit];
          step_o.nxt = P_FMANT;
        end else if (((ch_i == "e") || (ch_i == "E")) && flags_i[FlagDigit]) begin
          step_o.nxt = P_FEXP;
        end
      end
      P_FEXP, P_FESIGN, P_FEDIG: begin
        if ((phase_i == P_FEXP) && is_sign(ch_i)) begin
          step_o.nxt = P_FESIGN;
        end else if (is_digit(ch_i)) begin
          step_o.acc = 1'b1;
          step_o.nxt = P_FEDIG;
        end
      end
      P_ISTART, P_ISIGN, P_IDIG: begin
        if ((phase_i == P_ISTART) && is_sign(ch_i)) begin
          step_o.nxt = P_ISIGN;
        end else if (is_digit(ch_i)) begin
          step_o.acc = 1'b1;
          step_o.nxt = P_IDIG;
        end
      end
      P_SSTART: begin
        step_o.acc = 1'b1;
        if (ch_i == "\"") step_o.nxt = P_SIN;
      end
      P_SIN: begin
        step_o.acc = 1'b1;
        if (printable) begin
          step_o.nxt = ((ch_i == "\"") && !prev_bs_i) ? P_SDONE : P_SIN;
        end
      end
      P_YSTART: begin
        step_o.acc = 1'b1;
        if (is_sign(ch_i)) begin
          step_o.nxt = P_YPEC;
        end else if (is_initial(ch_i)) begin
          step_o.nxt = P_YBODY;
        end
      end
      P_YBODY: begin
        step_o.acc = 1'b1;
        if (is_subsequent(ch_i)) step_o.nxt = P_YBODY;
      end
      // idle, lone sign symbol and anything else end the scan
      default: begin
        step_o.nxt = P_IDLE;
      end
    endcase
  end

endmodule

// File: tb/sv/tb_sexp_token_end_recognizer.sv
`timescale 1ns / 1ps

module tb_sexp_token_end_recognizer
  import sexp_tok_pkg::*;
();

  localparam int TOK_MAX = 255;
  localparam int LEN_CAP = (TOK_MAX > 255) ? 255 : TOK_MAX;
  localparam int HOLD_LEN = 300;        // long output hold-off, in cycles
  localparam int WATCHDOG_LIMIT = 4000; // cycles with no beat anywhere
  localparam int PHASE_CHARS = 20;      // characters wanted per random phase
  localparam logic [7:0] DQUOTE = 8'h22;
  localparam logic [7:0] BSLASH = 8'h5C;
  localparam logic [7:0] NUL = 8'h00;

  typedef struct packed {
    logic [7:0] ch;
    logic       start;
  } text_beat_t;

  typedef struct packed {
    logic [7:0] len;
    logic       unterm;
    logic       too_long;
  } token_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic       s_axis_tuser = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_data_i = '0;

  sexp_token_end_recognizer #(
    .MAX_TOKEN_LEN(TOK_MAX)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Characters waiting to be offered, and tokens the scanner copy predicts
  text_beat_t text_q[$];
  token_t     token_q[$];
  logic [7:0] word_q[$];   // token under construction

  int n_pushed = 0;
  int n_chars = 0;
  int n_tokens = 0;
  int n_errors = 0;
  int idle_cycles = 0;

  // Pacing knobs, changed only between phases; hold_cnt counts the hold-off
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_armed = 1'b0;
  int hold_cnt = 0;

  string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  string sym_marks = "!$%&*/:<=>?^_~";
  string tail_extra = "+-.@";

  // Scanner copy: grammar select and scan state
  kind_e      tok_kind;
  logic       scan_on;
  phase_e     cur_phase;
  logic [7:0] used_cnt;
  logic [7:0] best_len;
  logic       esc_pending;
  logic [1:0] mant;        // bit 0 digit seen, bit 1 point seen

  // ---------------------------------------------------------------------------
  // Character classes
  // ---------------------------------------------------------------------------
  function automatic logic ch_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic ch_sign(logic [7:0] c);
    return c == "+" || c == "-";
  endfunction

  function automatic logic ch_blank(logic [7:0] c);
    return c == 8'h20 || c == 8'h0A || c == 8'h0D || c == 8'h09;
  endfunction

  function automatic logic ch_delim(logic [7:0] c);
    return c == "(" || c == ")" || c == ";";
  endfunction

  function automatic logic ch_sym_head(logic [7:0] c);
    logic mark;
    mark = 1'b0;
    for (int i = 0; i < sym_marks.len(); i++)
      if (c == sym_marks[i]) mark = 1'b1;
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || mark;
  endfunction

  function automatic logic ch_sym_tail(logic [7:0] c);
    return ch_sym_head(c) || ch_digit(c) || ch_sign(c) || c == "." || c == "@";
  endfunction

  function automatic phase_e first_phase(kind_e k);
    case (k)
      K_FLOAT: return P_FSTART;
      K_INT:   return P_ISTART;
      K_STR:   return P_SSTART;
      default: return P_YSTART;
    endcase
  endfunction

  // Close the scan and hand back its token
  function automatic void close_scan(output token_t r, input logic [7:0] len,
                                     input logic unterm, input logic too_long);
    r.len = len;
    r.unterm = unterm;
    r.too_long = too_long;
    scan_on = 1'b0;
    cur_phase = P_IDLE;
  endfunction

  // Fold one character into the scan; returns 1 when a token is finished
  function automatic bit scan_char(input logic [7:0] c, input logic st, output token_t r);
    phase_e     nxt;
    logic       acc;
    logic [1:0] fl;
    r = '0;
    if (st) begin
      scan_on = 1'b1;
      cur_phase = first_phase(tok_kind);
      used_cnt = '0;
      best_len = '0;
      esc_pending = 1'b0;
      mant = '0;
    end
    if (!scan_on) return 0;

    fl = mant;
    acc = 1'b0;
    nxt = P_IDLE;
    case (cur_phase)
      P_FSTART, P_FMANT: begin
        if (cur_phase == P_FSTART && ch_sign(c)) begin
          nxt = P_FMANT;
        end else if (ch_digit(c)) begin
          fl[0] = 1'b1;
          acc = fl[1];
          nxt = P_FMANT;
        end else if (c == "." && !fl[1]) begin
          fl[1] = 1'b1;
          acc = fl[0];
          nxt = P_FMANT;
        end else if ((c == "e" || c == "E") && fl[0]) begin
          nxt = P_FEXP;
        end
      end
      P_FEXP, P_FESIGN, P_FEDIG: begin
        if (cur_phase == P_FEXP && ch_sign(c)) begin
          nxt = P_FESIGN;
        end else if (ch_digit(c)) begin
          acc = 1'b1;
          nxt = P_FEDIG;
        end
      end
      P_ISTART, P_ISIGN, P_IDIG: begin
        if (cur_phase == P_ISTART && ch_sign(c)) begin
          nxt = P_ISIGN;
        end else if (ch_digit(c)) begin
          acc = 1'b1;
          nxt = P_IDIG;
        end
      end
      P_SSTART: begin
        acc = 1'b1;
        if (c == DQUOTE) nxt = P_SIN;
      end
      P_SIN: begin
        acc = 1'b1;
        if ((c >= 8'h21 && c <= 8'h7E) || ch_blank(c))
          nxt = (c == DQUOTE && !esc_pending) ? P_SDONE : P_SIN;
      end
      P_YSTART: begin
        acc = 1'b1;
        if (ch_sign(c)) nxt = P_YPEC;
        else if (ch_sym_head(c)) nxt = P_YBODY;
      end
      P_YBODY: begin
        acc = 1'b1;
        if (ch_sym_tail(c)) nxt = P_YBODY;
      end
      default: ;
    endcase

    if (nxt == P_IDLE) begin
      // A symbol only counts when a delimiter or blank follows it
      if ((cur_phase == P_YPEC || cur_phase == P_YBODY) && !ch_delim(c) && !ch_blank(c))
        close_scan(r, 8'd0, 1'b0, 1'b0);
      else
        close_scan(r, best_len, cur_phase == P_SIN, 1'b0);
      return 1;
    end
    if (used_cnt >= LEN_CAP) begin
      close_scan(r, best_len, cur_phase == P_SIN, 1'b1);
      return 1;
    end
    used_cnt = used_cnt + 8'd1;
    esc_pending = (cur_phase == P_SIN && c == BSLASH && !esc_pending);
    mant = fl;
    if (acc) best_len = used_cnt;
    if (nxt == P_SDONE) begin
      // Closing quote ends the string on this very character
      close_scan(r, used_cnt, 1'b0, 1'b0);
      return 1;
    end
    cur_phase = nxt;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(3))
      0: return 8'h20;
      1: return 8'h0A;
      2: return 8'h0D;
      default: return 8'h09;
    endcase
  endfunction

  // A blank or delimiter with good_pct percent chance, else end of text or any byte
  function automatic logic [7:0] pick_follower(int good_pct);
    if ($urandom_range(99) < good_pct)
      return ($urandom_range(1) == 0) ? pick_blank() : pick("();");
    if ($urandom_range(3) == 0) return NUL;
    return 8'($urandom_range(255));
  endfunction

  task automatic push_ch(logic [7:0] c, logic st);
    text_q.push_back('{ch: c, start: st});
    n_pushed++;
  endtask

  task automatic add(logic [7:0] c);
    word_q.push_back(c);
  endtask

  // Push the built token; its first character opens a scan
  task automatic emit_word();
    foreach (word_q[i]) push_ch(word_q[i], i == 0);
    word_q.delete();
  endtask

  task automatic make_float();
    if ($urandom_range(2) == 0) add(pick("+-"));
    repeat ($urandom_range(4)) add(pick_digit());
    if ($urandom_range(1)) begin
      add(".");
      repeat ($urandom_range(3)) add(pick_digit());
    end
    if ($urandom_range(2) != 0) begin
      add(pick("eE"));
      if ($urandom_range(1)) add(pick("+-"));
      repeat ($urandom_range(3)) add(pick_digit());
    end
    add(pick_follower(70));
  endtask

  task automatic make_int();
    if ($urandom_range(2) == 0) add(pick("+-"));
    repeat ($urandom_range(5)) add(pick_digit());
    add(pick_follower(60));
  endtask

  task automatic make_string();
    add(($urandom_range(9) != 0) ? DQUOTE : 8'($urandom_range(8'h21, 8'h7E)));
    repeat ($urandom_range(8)) begin
      case ($urandom_range(9))
        0: begin
          add(BSLASH);
          add(($urandom_range(1) == 0) ? DQUOTE : 8'($urandom_range(8'h21, 8'h7E)));
        end
        1: add(pick_blank());
        default: add(8'($urandom_range(8'h21, 8'h7E)));
      endcase
    end
    add(($urandom_range(4) != 0) ? DQUOTE : pick_follower(0));
  endtask

  task automatic make_symbol();
    if ($urandom_range(4) == 0) begin
      add(pick("+-"));
    end else begin
      add(($urandom_range(1) == 0) ? pick(letters) : pick(sym_marks));
      repeat ($urandom_range(6)) begin
        case ($urandom_range(3))
          0: add(pick(letters));
          1: add(pick_digit());
          2: add(pick(sym_marks));
          default: add(pick(tail_extra));
        endcase
      end
    end
    add(pick_follower(75));
  endtask

  task automatic make_token(kind_e k);
    case (k)
      K_FLOAT: make_float();
      K_INT:   make_int();
      K_STR:   make_string();
      default: make_symbol();
    endcase
  endtask

  // Token body of n characters, near or past the length cap
  task automatic make_long(kind_e k, int n);
    case (k)
      K_FLOAT: begin
        add("1");
        add(".");
        repeat (n - 2) add(pick_digit());
      end
      K_INT: repeat (n) add(pick_digit());
      K_STR: begin
        add(DQUOTE);
        repeat (n - 1) add(8'($urandom_range(8'h23, 8'h5B)));
      end
      default: begin
        add(pick(letters));
        repeat (n - 1) add(pick(letters));
      end
    endcase
    add((k == K_STR) ? DQUOTE : pick_follower(100));
    emit_word();
  endtask

  // Directed token: text, then one character that should end it
  task automatic dir(string s, logic [7:0] follower);
    for (int i = 0; i < s.len(); i++) add(s[i]);
    add(follower);
    emit_word();
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 6)) push_ch(8'($urandom_range(255)), $urandom_range(7) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Phase control
  // ---------------------------------------------------------------------------
  task automatic drain();
    do @(negedge clk_i);
    while (text_q.size() != 0 || s_axis_tvalid || token_q.size() != 0);
    // Let any scan that gave no token settle
    repeat (4) @(negedge clk_i);
  endtask

  // End of text with a fresh scan always yields a token, leaving the block idle
  task automatic finish_phase();
    push_ch(NUL, 1'b1);
    drain();
  endtask

  task automatic set_kind(kind_e k);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= k;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(kind_e k, int n_chars_wanted);
    int target;
    int r;
    target = n_pushed + n_chars_wanted;
    while (n_pushed < target) begin
      r = $urandom_range(99);
      if (r < 75) begin
        make_token(k);
        // Break one character now and then
        if ($urandom_range(9) == 0)
          word_q[$urandom_range(word_q.size() - 1)] = 8'($urandom_range(255));
        emit_word();
      end else if (r < 85) begin
        make_token(kind_e'($urandom_range(3)));
        emit_word();
      end else if (r < 95) begin
        noise_burst();
      end else begin
        // Drop the follower so the next token restarts a live scan
        make_token(k);
        void'(word_q.pop_back());
        emit_word();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer pending characters, idling at random
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    text_beat_t b;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        b = text_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b.ch;
        s_axis_tuser <= b.start;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off once armed
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_armed && hold_cnt < HOLD_LEN) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check finished tokens, then predict from accepted characters
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    token_t got;
    token_t want;
    token_t pred;
    if (!rst_ni) begin
      tok_kind = K_FLOAT;
      scan_on = 1'b0;
      cur_phase = P_IDLE;
      used_cnt = '0;
      best_len = '0;
      esc_pending = 1'b0;
      mant = '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{len: m_axis_tdata, unterm: m_axis_tuser[0], too_long: m_axis_tuser[1]};
        n_tokens++;
        if (token_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected token: expected none, got len=%0d unterm=%0b too_long=%0b",
                   $time, got.len, got.unterm, got.too_long);
        end else begin
          want = token_q.pop_front();
          if (got.len !== want.len || got.unterm !== want.unterm ||
              got.too_long !== want.too_long) begin
            n_errors++;
            $display("%0t: token mismatch: expected len=%0d unterm=%0b too_long=%0b, got len=%0d unterm=%0b too_long=%0b",
                     $time, want.len, want.unterm, want.too_long,
                     got.len, got.unterm, got.too_long);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) tok_kind = kind_e'(cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        n_chars++;
        if (scan_char(s_axis_tdata, s_axis_tuser, pred)) token_q.push_back(pred);
      end
    end
  end

  // Watchdog: end the run if no beat moves on any channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d tokens outstanding",
                 $time, idle_cycles, token_q.size());
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int idle_mix[4];
    int stall_mix[4];
    idle_mix = '{0, 77, 0, 26};
    stall_mix = '{0, 0, 77, 26};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed float: point, exponent, lone point, missing exponent, over the cap
    set_kind(K_FLOAT);
    dir("1", " ");
    dir("1e5", ";");
    dir("12.5E-3", 8'h0A);
    dir(".", "x");
    dir(".e5", " ");
    dir("-.5", NUL);
    dir("+7.", ")");
    dir("9e", "+");
    make_long(K_FLOAT, 256);
    finish_phase();

    // Directed integer, including a restart in the middle of a scan
    set_kind(K_INT);
    dir("-", " ");
    dir("+123", "a");
    dir("0", 8'hFF);
    push_ch("4", 1'b1);
    push_ch("2", 1'b0);
    dir("99999", NUL);
    finish_phase();

    // Directed string: escaped quote, open strings, idle characters after close
    set_kind(K_STR);
    dir("\"ab\\\"c", DQUOTE);
    push_ch("z", 1'b0);
    push_ch(8'hFF, 1'b0);
    dir("\"open", NUL);
    dir("\"x\t", 8'h80);
    dir("a", " ");
    dir("\"", DQUOTE);
    make_long(K_STR, 255);
    finish_phase();

    // Directed symbol: peculiar signs, bad followers, marks, exactly at the cap
    set_kind(K_SYM);
    dir("+", " ");
    dir("-", "a");
    dir("lambda?", "(");
    dir("x1.@+-", ")");
    dir("a", NUL);
    dir("~!", ";");
    dir("1", " ");
    make_long(K_SYM, 255);
    finish_phase();

    // Random phases: every grammar under every pacing mix
    for (int m = 0; m < 4; m++) begin
      send_idle_pct = idle_mix[m];
      recv_stall_pct = stall_mix[m];
      for (int k = 0; k < 4; k++) begin
        set_kind(kind_e'(k));
        run_random(kind_e'(k), PHASE_CHARS);
        finish_phase();
      end
    end

    // Back-pressure: hold the output off while short symbols keep arriving
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_kind(K_SYM);
    hold_armed = 1'b1;
    repeat (30) begin
      make_symbol();
      emit_word();
    end
    finish_phase();

    repeat (8) @(posedge clk_i);
    foreach (token_q[i]) begin
      n_errors++;
      $display("%0t: missing token: expected len=%0d unterm=%0b too_long=%0b, got none",
               $time, token_q[i].len, token_q[i].unterm, token_q[i].too_long);
    end

    $display("Scanned %0d characters into %0d tokens over float, integer, string and symbol",
             n_chars, n_tokens);
    $display("grammars, with four pacing mixes, tokens at the length cap and a %0d-cycle stall.",
             HOLD_LEN);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
